### hw/rtl/tvsd_pkg.sv
// Shared types and constants for the tagged varint stream decoder.
`timescale 1ns / 1ps

package tvsd_pkg;

  // Parser position within the current item.
  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_HEAD  = 3'd1,
    PH_BYTES = 3'd2,
    PH_CHAR  = 3'd3,
    PH_STR   = 3'd4
  } tvsd_phase_e;

  // Kind of a decoded item.
  typedef enum logic [2:0] {
    K_BOOL  = 3'd0,
    K_CHAR  = 3'd1,
    K_SHORT = 3'd2,
    K_INT   = 3'd3,
    K_LONG  = 3'd4,
    K_SLEN  = 3'd5,
    K_SCHR  = 3'd6
  } tvsd_kind_e;

  // Error codes carried with a result.
  typedef enum logic [2:0] {
    E_OK        = 3'd0,
    E_BAD_TAG   = 3'd1,
    E_BAD_LEN   = 3'd2,
    E_SHORT_OVF = 3'd3,
    E_INT_OVF   = 3'd4,
    E_TRUNC     = 3'd5
  } tvsd_err_e;

  // Tag bytes.
  localparam logic [7:0] TAG_TRUE  = 8'h74;  // 't'
  localparam logic [7:0] TAG_FALSE = 8'h66;  // 'f'
  localparam logic [7:0] TAG_CHAR  = 8'h63;  // 'c'
  localparam logic [7:0] TAG_SHORT = 8'h73;  // 's'
  localparam logic [7:0] TAG_INT   = 8'h69;  // 'i'
  localparam logic [7:0] TAG_LONG  = 8'h6C;  // 'l'
  localparam logic [7:0] TAG_STR   = 8'h53;  // 'S'

  // Largest count of extra bytes a number head may announce.
  localparam logic [3:0] MAX_EXTRA_BYTES = 4'd8;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } tvsd_in_t;

  // Output word.
  typedef struct packed {
    tvsd_kind_e         kind;
    logic signed [63:0] value;
    logic               last_of_string;
    tvsd_err_e          error;
  } tvsd_out_t;

  // Result handed from the parser to the output register.
  typedef struct packed {
    logic      valid;
    tvsd_out_t word;
  } tvsd_res_t;

endpackage

### hw/rtl/tvsd_in_reg.sv
// Input register that holds one stream word until the parser consumes it.
`timescale 1ns / 1ps

module tvsd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tvsd_pkg::tvsd_in_t in_word_i,
  input  logic            step_ok_i,
  output logic            hold_valid_o,
  output tvsd_pkg::tvsd_in_t hold_word_o
);
  import tvsd_pkg::*;

  logic     valid_q;
  tvsd_in_t word_q;

  // The held word blocks a new one only when it cannot advance this cycle.
  assign in_stall_o   = valid_q && !step_ok_i;
  assign hold_valid_o = valid_q;
  assign hold_word_o  = word_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

endmodule

### hw/rtl/tvsd_parser.sv
// Parser state and the per-byte decode step.
`timescale 1ns / 1ps

module tvsd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tvsd_pkg::tvsd_in_t  word_i,
  output tvsd_pkg::tvsd_res_t res_o
);
  import tvsd_pkg::*;

  tvsd_phase_e phase_q, phase_d;
  tvsd_kind_e  kind_q, kind_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [5:0]  top_bit_q, top_bit_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] chars_left_q, chars_left_d;

  logic [7:0]  b;
  logic [3:0]  head_n;
  logic [63:0] num_raw;
  logic [5:0]  num_top;
  logic [63:0] ext_mask;
  logic [63:0] num_ext;
  logic        short_ovf;
  logic        int_ovf;
  logic [63:0] chars_dec;

  assign b      = word_i.data_byte;
  assign head_n = b[7:4];

  // Candidate number: either a head with no extra bytes, or the last byte shifted in.
  assign num_raw = (phase_q == PH_HEAD) ? {60'd0, b[3:0]} : {acc_q[55:0], b};
  assign num_top = (phase_q == PH_HEAD) ? 6'd3 : top_bit_q;

  // Sign extension from the announced sign bit.
  assign ext_mask = {64{1'b1}} << num_top;
  assign num_ext  = ((num_top != 6'd63) && num_raw[num_top]) ? (num_raw | ext_mask) : num_raw;

  // Range checks: the upper bits must all match the sign bit of the narrow type.
  assign short_ovf = !((&num_ext[63:15]) || !(|num_ext[63:15]));
  assign int_ovf   = !((&num_ext[63:31]) || !(|num_ext[63:31]));

  assign chars_dec = chars_left_q - 64'd1;

  // Next state and result for one accepted word.
  always_comb begin
    logic finish;
    phase_d      = phase_q;
    kind_d       = kind_q;
    bytes_left_d = bytes_left_q;
    top_bit_d    = top_bit_q;
    acc_d        = acc_q;
    chars_left_d = chars_left_q;
    res_o        = '0;
    finish       = 1'b0;

    if (step_i) begin
      if (word_i.end_of_stream) begin
        // A stream that ends inside an item reports truncation and starts over.
        if (phase_q != PH_TAG) begin
          res_o.valid      = 1'b1;
          res_o.word.kind  = (phase_q == PH_STR) ? K_SCHR : kind_q;
          res_o.word.error = E_TRUNC;
        end
        phase_d      = PH_TAG;
        kind_d       = K_BOOL;
        bytes_left_d = '0;
        top_bit_d    = '0;
        acc_d        = '0;
        chars_left_d = '0;
      end else begin
        unique case (phase_q)
          PH_TAG: begin
            unique case (b)
              TAG_TRUE: begin
                res_o.valid      = 1'b1;
                res_o.word.kind  = K_BOOL;
                res_o.word.value = 64'sd1;
              end
              TAG_FALSE: begin
                res_o.valid     = 1'b1;
                res_o.word.kind = K_BOOL;
              end
              TAG_CHAR: begin
                kind_d  = K_CHAR;
                phase_d = PH_CHAR;
              end
              TAG_SHORT: begin
                kind_d  = K_SHORT;
                phase_d = PH_HEAD;
              end
              TAG_INT: begin
                kind_d  = K_INT;
                phase_d = PH_HEAD;
              end
              TAG_LONG: begin
                kind_d  = K_LONG;
                phase_d = PH_HEAD;
              end
              TAG_STR: begin
                kind_d  = K_SLEN;
                phase_d = PH_HEAD;
              end
              default: begin
                res_o.valid      = 1'b1;
                res_o.word.kind  = K_BOOL;
                res_o.word.value = {56'd0, b};
                res_o.word.error = E_BAD_TAG;
              end
            endcase
          end
          PH_HEAD: begin
            if (head_n > MAX_EXTRA_BYTES) begin
              phase_d          = PH_TAG;
              res_o.valid      = 1'b1;
              res_o.word.kind  = kind_q;
              res_o.word.error = E_BAD_LEN;
            end else begin
              bytes_left_d = head_n;
              // A full eight-byte number drops the nibble; it shifts out anyway.
              if (head_n == MAX_EXTRA_BYTES) begin
                top_bit_d = 6'd63;
                acc_d     = '0;
              end else begin
                top_bit_d = {head_n[2:0], 3'b011};
                acc_d     = {60'd0, b[3:0]};
              end
              if (head_n == 4'd0) begin
                finish = 1'b1;
              end else begin
                phase_d = PH_BYTES;
              end
            end
          end
          PH_BYTES: begin
            acc_d        = {acc_q[55:0], b};
            bytes_left_d = bytes_left_q - 4'd1;
            if (bytes_left_q == 4'd1) begin
              finish = 1'b1;
            end
          end
          PH_CHAR: begin
            phase_d          = PH_TAG;
            res_o.valid      = 1'b1;
            res_o.word.kind  = K_CHAR;
            res_o.word.value = {56'd0, b};
          end
          PH_STR: begin
            chars_left_d     = chars_dec;
            res_o.valid      = 1'b1;
            res_o.word.kind  = K_SCHR;
            res_o.word.value = {56'd0, b};
            if (chars_dec == 64'd0) begin
              phase_d                   = PH_TAG;
              res_o.word.last_of_string = 1'b1;
            end
          end
          default: begin
            phase_d      = PH_TAG;
            kind_d       = K_BOOL;
            bytes_left_d = '0;
            top_bit_d    = '0;
            acc_d        = '0;
            chars_left_d = '0;
          end
        endcase
      end

      // A completed number: range check, and a positive string length opens the characters.
      if (finish) begin
        phase_d          = PH_TAG;
        res_o.valid      = 1'b1;
        res_o.word.kind  = kind_q;
        res_o.word.value = num_ext;
        if ((kind_q == K_SHORT) && short_ovf) begin
          res_o.word.error = E_SHORT_OVF;
        end else if ((kind_q == K_INT) && int_ovf) begin
          res_o.word.error = E_INT_OVF;
        end else if ((kind_q == K_SLEN) && (num_ext != 64'd0) && !num_ext[63]) begin
          chars_left_d = num_ext;
          phase_d      = PH_STR;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAG;
      kind_q       <= K_BOOL;
      bytes_left_q <= '0;
      top_bit_q    <= '0;
      acc_q        <= '0;
      chars_left_q <= '0;
    end else begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      bytes_left_q <= bytes_left_d;
      top_bit_q    <= top_bit_d;
      acc_q        <= acc_d;
      chars_left_q <= chars_left_d;
    end
  end

endmodule

### hw/rtl/tvsd_out_reg.sv
// Result register that presents one decoded word to the consumer.
`timescale 1ns / 1ps

module tvsd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tvsd_pkg::tvsd_res_t res_i,
  output logic                step_ok_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tvsd_pkg::tvsd_out_t out_word_o
);
  import tvsd_pkg::*;

  logic      valid_q;
  tvsd_out_t word_q;

  // The register can take a new result when empty or being emptied.
  assign step_ok_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_ok_o) begin
      valid_q <= res_i.valid;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (step_ok_o && res_i.valid) begin
      word_q <= res_i.word;
    end
  end

endmodule

### hw/rtl/tagged_varint_stream_decoder_core.sv
// Top level of the tagged varint stream decoder.
//
//   Channel  Direction  Handshake                Word
//   in       input      in_valid_i / in_stall_o  tvsd_in_t: data_byte, end_of_stream
//   out      output     out_valid_o/out_stall_i  tvsd_out_t: kind, value,
//                                                last_of_string, error
//
// One byte enters per cycle while in_stall_o is low; each byte is decoded combinationally
// between the input register and the result register.
// A result is registered after its byte is decoded and leaves while out_stall_i is low.
// Reset (rst_ni low) empties both registers and returns the parser to the tag phase.
// A stall on the output holds the result and at once holds the word in the input register.
`timescale 1ns / 1ps

module tagged_varint_stream_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tvsd_pkg::tvsd_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tvsd_pkg::tvsd_out_t out_word_o
);
  import tvsd_pkg::*;

  logic      step_ok;
  logic      hold_valid;
  tvsd_in_t  hold_word;
  tvsd_res_t res;

  // Input register.
  tvsd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .step_ok_i    (step_ok),
    .hold_valid_o (hold_valid),
    .hold_word_o  (hold_word)
  );

  // Decode step on the held byte.
  tvsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (hold_valid && step_ok),
    .word_i (hold_word),
    .res_o  (res)
  );

  // Result register.
  tvsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .step_ok_o   (step_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
